// ===== rtl/ctr_pkg.sv =====
// Shared types and constants for the cache tag and replacement core.
// No dependencies; imported by the core module.
package ctr_pkg;

  localparam int unsigned NUM_BLOCKS_DEF = 64;
  localparam int unsigned SET_WAYS_LOG2  = 2;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned TAG_W          = 32;
  localparam int unsigned STAMP_W        = 32;
  localparam int unsigned RECENT_W       = 6;
  localparam int unsigned LFSR_W         = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ASSOC  = 3'd0,
    CFG_POLICY = 3'd1,
    CFG_OFFSET = 3'd2,
    CFG_BLKLOG = 3'd3,
    CFG_SEED   = 3'd4
  } cfg_idx_t;

  // Placement modes and replacement policies.
  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_SET4   = 2'd1;
  localparam logic [1:0] POL_FIFO    = 2'd0;
  localparam logic [1:0] POL_LRU     = 2'd1;
  localparam logic [1:0] POL_RANDOM  = 2'd2;

  // Sequencer states.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_DRAW   = 6'b001000,
    S_RDV    = 6'b010000,
    S_REPL   = 6'b100000
  } state_t;

endpackage

// ===== rtl/cache_tag_replacement_core.sv =====
// Cache tag store model with direct-mapped, four-way or fully associative placement
// and FIFO, LRU or random replacement. A transaction scans the ways of its set, one
// entry per cycle through the tag and stamp memories, then takes a hit, fills an empty
// line, or picks a victim (the oldest stamp, or a random draw) and replaces it.
// busy stays high until the result strobe; the receiver cannot stall.
// Synchronous active-low reset clears the valid bits and control state.
module cache_tag_replacement_core
  import ctr_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [ADDR_W-1:0] in_address,
  output logic              out_valid,
  output logic              out_evicted,
  output logic [TAG_W-1:0]  out_victim_tag,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned MAXLB = $clog2(NUM_BLOCKS + 1) - 1;
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned EXW   = ((IDX_W > RECENT_W) ? IDX_W : RECENT_W) + 1;

  // Configuration registers.
  logic [1:0]  assoc_r, policy_r;
  logic [4:0]  offset_r;
  logic [2:0]  blklog_r;

  // Line storage.
  logic [NUM_BLOCKS-1:0] valid_r;
  logic [TAG_W-1:0]      tag_mem [NUM_BLOCKS];
  logic [STAMP_W-1:0]    stamp_mem [NUM_BLOCKS];
  logic [TAG_W-1:0]      tag_q;
  logic [STAMP_W-1:0]    stamp_q;
  logic                  vq_r, vq_nxt;

  // Sequencer and working registers.
  state_t               state_r, state_nxt;
  logic [STAMP_W-1:0]   clock_r, clock_nxt;
  logic [RECENT_W-1:0]  recent_r, recent_nxt;
  logic [LFSR_W-1:0]    lfsr_r, lfsr_nxt;
  logic [TAG_W-1:0]     tag_r, tag_nxt;
  logic [IDX_W-1:0]     base_r, base_nxt;
  logic [CNT_W-1:0]     ways_r, ways_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     cmp_w_r, cmp_w_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic                 hit_f_r, hit_f_nxt, empty_f_r, empty_f_nxt;
  logic [IDX_W-1:0]     hit_w_r, hit_w_nxt, empty_w_r, empty_w_nxt;
  logic [IDX_W-1:0]     min_w_r, min_w_nxt, max_w_r, max_w_nxt;
  logic [STAMP_W-1:0]   min_s_r, min_s_nxt, max_s_r, max_s_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [EXW-1:0]       excl_r, excl_nxt;
  logic                 ov_r, ov_nxt, oe_r, oe_nxt;
  logic [TAG_W-1:0]     ot_r, ot_nxt;

  // Decode and memory control signals.
  logic [3:0]          lb;
  logic [3:0]          wlog, idx_bits;
  logic [IDX_W-1:0]    set_mask, set_idx;
  logic [6:0]          tag_sh;
  logic [IDX_W-1:0]    rd_addr, way_mask;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [LFSR_W-1:0]   lfsr_step;
  logic [IDX_W-1:0]    draw;
  logic [IDX_W-1:0]    last_w;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid      = ov_r;
  assign out_evicted    = oe_r;
  assign out_victim_tag = ot_r;

  // Address split from the current configuration.
  always_comb begin
    if (blklog_r > 3'(MAXLB > 7 ? 7 : MAXLB) && MAXLB < 7) lb = 4'(MAXLB);
    else if (blklog_r < 3'd2) lb = 4'd2;
    else lb = {1'b0, blklog_r};
    case (assoc_r)
      MODE_DIRECT: wlog = 4'd0;
      MODE_SET4:   wlog = 4'(SET_WAYS_LOG2);
      default:     wlog = lb;
    endcase
    idx_bits = lb - wlog;
    set_mask = ~({IDX_W{1'b1}} << idx_bits);
    set_idx  = IDX_W'(in_address >> offset_r) & set_mask;
    tag_sh   = 7'(offset_r) + 7'(idx_bits);
  end

  assign way_mask  = IDX_W'(ways_r - CNT_W'(1));
  assign last_w    = way_mask;
  assign rd_addr   = (state_r == S_SCAN) ? (base_r | IDX_W'(cnt_r)) : (base_r | pick_r);
  assign lfsr_step = {1'b0, lfsr_r[LFSR_W-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);
  assign draw      = IDX_W'(lfsr_step) & way_mask;

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt   = state_r;
    clock_nxt   = clock_r;
    recent_nxt  = recent_r;
    lfsr_nxt    = lfsr_r;
    tag_nxt     = tag_r;
    base_nxt    = base_r;
    ways_nxt    = ways_r;
    cnt_nxt     = cnt_r;
    cmp_w_nxt   = IDX_W'(cnt_r);
    cmp_vld_nxt = 1'b0;
    vq_nxt      = valid_r[rd_addr];
    hit_f_nxt   = hit_f_r;
    hit_w_nxt   = hit_w_r;
    empty_f_nxt = empty_f_r;
    empty_w_nxt = empty_w_r;
    min_w_nxt   = min_w_r;
    min_s_nxt   = min_s_r;
    max_w_nxt   = max_w_r;
    max_s_nxt   = max_s_r;
    pick_nxt    = pick_r;
    excl_nxt    = excl_r;
    ov_nxt      = 1'b0;
    oe_nxt      = oe_r;
    ot_nxt      = ot_r;
    mem_we      = 1'b0;
    mem_waddr   = base_r | pick_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          tag_nxt     = in_address >> tag_sh;
          base_nxt    = IDX_W'(set_idx << wlog);
          ways_nxt    = CNT_W'(1) << wlog;
          cnt_nxt     = '0;
          hit_f_nxt   = 1'b0;
          empty_f_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end
      end
      // Issue one read per cycle and fold in the entry read the cycle before.
      S_SCAN: begin
        if (cnt_r < ways_r) begin
          cnt_nxt     = cnt_r + CNT_W'(1);
          cmp_vld_nxt = 1'b1;
        end
        if (cmp_vld_r) begin
          if (vq_r && tag_q == tag_r && !hit_f_r) begin
            hit_f_nxt = 1'b1;
            hit_w_nxt = cmp_w_r;
          end
          if (!vq_r && !empty_f_r) begin
            empty_f_nxt = 1'b1;
            empty_w_nxt = cmp_w_r;
          end
          if (cmp_w_r == '0 || stamp_q < min_s_r) begin
            min_s_nxt = stamp_q;
            min_w_nxt = cmp_w_r;
          end
          if (cmp_w_r == '0 || stamp_q > max_s_r) begin
            max_s_nxt = stamp_q;
            max_w_nxt = cmp_w_r;
          end
          if (cmp_w_r == last_w) state_nxt = S_DECIDE;
        end
      end
      // Hit, fill of an empty line, or choice of a victim.
      S_DECIDE: begin
        if (hit_f_r) begin
          mem_waddr  = base_r | hit_w_r;
          mem_we     = (policy_r == POL_LRU) || (policy_r == POL_RANDOM);
          recent_nxt = RECENT_W'(base_r | hit_w_r);
          clock_nxt  = clock_r + STAMP_W'(1);
          ov_nxt     = 1'b1;
          oe_nxt     = 1'b0;
          ot_nxt     = '0;
          state_nxt  = S_IDLE;
        end else if (empty_f_r) begin
          mem_waddr  = base_r | empty_w_r;
          mem_we     = 1'b1;
          recent_nxt = RECENT_W'(base_r | empty_w_r);
          clock_nxt  = clock_r + STAMP_W'(1);
          ov_nxt     = 1'b1;
          oe_nxt     = 1'b0;
          ot_nxt     = '0;
          state_nxt  = S_IDLE;
        end else if (policy_r == POL_RANDOM && ways_r > CNT_W'(1)) begin
          if (assoc_r == MODE_SET4) excl_nxt = EXW'(max_w_r);
          else excl_nxt = EXW'(recent_r) - EXW'(base_r);
          state_nxt = S_DRAW;
        end else begin
          pick_nxt  = min_w_r;
          state_nxt = S_RDV;
        end
      end
      // One LFSR step per cycle until the draw misses the excluded way.
      S_DRAW: begin
        lfsr_nxt = lfsr_step;
        pick_nxt = draw;
        if (EXW'(draw) != excl_r) state_nxt = S_RDV;
      end
      // Victim tag read is in flight.
      S_RDV: begin
        state_nxt = S_REPL;
      end
      S_REPL: begin
        mem_we     = 1'b1;
        recent_nxt = RECENT_W'(base_r | pick_r);
        clock_nxt  = clock_r + STAMP_W'(1);
        ov_nxt     = 1'b1;
        oe_nxt     = 1'b1;
        ot_nxt     = tag_q;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Seed write reloads the LFSR; zero is forced to one.
    if (cfg_valid && cfg_ready && cfg_index == CFG_SEED) begin
      lfsr_nxt = (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
    end
  end

  // Tag and stamp memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_waddr]   <= tag_r;
      stamp_mem[mem_waddr] <= clock_r;
    end
    tag_q   <= tag_mem[rd_addr];
    stamp_q <= stamp_mem[rd_addr];
  end

  // Control state, valid bits and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      clock_r   <= STAMP_W'(1);
      recent_r  <= '0;
      lfsr_r    <= LFSR_W'(1);
      assoc_r   <= MODE_DIRECT;
      policy_r  <= POL_FIFO;
      offset_r  <= 5'd4;
      blklog_r  <= 3'd6;
      ov_r      <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clock_r   <= clock_nxt;
      recent_r  <= recent_nxt;
      lfsr_r    <= lfsr_nxt;
      ov_r      <= ov_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      if (mem_we) valid_r[mem_waddr] <= 1'b1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ASSOC:  assoc_r  <= cfg_data[1:0];
          CFG_POLICY: policy_r <= (cfg_data[1:0] == 2'd3) ? POL_FIFO : cfg_data[1:0];
          CFG_OFFSET: offset_r <= cfg_data[4:0];
          CFG_BLKLOG: blklog_r <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    vq_r      <= vq_nxt;
    tag_r     <= tag_nxt;
    base_r    <= base_nxt;
    ways_r    <= ways_nxt;
    cnt_r     <= cnt_nxt;
    cmp_w_r   <= cmp_w_nxt;
    hit_f_r   <= hit_f_nxt;
    hit_w_r   <= hit_w_nxt;
    empty_f_r <= empty_f_nxt;
    empty_w_r <= empty_w_nxt;
    min_w_r   <= min_w_nxt;
    min_s_r   <= min_s_nxt;
    max_w_r   <= max_w_nxt;
    max_s_r   <= max_s_nxt;
    pick_r    <= pick_nxt;
    excl_r    <= excl_nxt;
    oe_r      <= oe_nxt;
    ot_r      <= ot_nxt;
  end

endmodule
